[sv/mhq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mhq_pkg: shared types and codes for the max-heap unit
// Request and status codes, data width and the per-cell control bundle.
// ----------------------------------------------------------------------------
package mhq_pkg;

  localparam int DATA_W       = 32;
  localparam int COUNT_W      = 9;
  localparam int CAP_DEFAULT  = 256;
  localparam int GROUP_SIZE   = 16;

  localparam logic FN_INSERT = 1'b0;
  localparam logic FN_DELETE = 1'b1;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } cell_ctrl_t;

endpackage : mhq_pkg
`default_nettype wire

[sv/mhq_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mhq_cell: one slot of the sorted entry chain
// Holds one value; compares it with the request key and, on update, keeps it,
// takes the key, or takes a neighbor's value so the chain stays descending.
// ----------------------------------------------------------------------------
module mhq_cell (
  input  logic                                clk,
  input  mhq_pkg::cell_ctrl_t                 ctrl,
  input  logic signed [mhq_pkg::DATA_W-1:0]   key,
  input  logic                                valid,
  input  logic signed [mhq_pkg::DATA_W-1:0]   prev_data,
  input  logic                                prev_ge,
  input  logic signed [mhq_pkg::DATA_W-1:0]   next_data,
  output logic signed [mhq_pkg::DATA_W-1:0]   data,
  output logic                                ge,
  output logic                                eq
);
  import mhq_pkg::*;

  logic gt;

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      gt <= valid && (data > key);
      eq <= valid && (data == key);
    end
  end

  assign ge = gt | eq;

  // insert: slots at or above the key stay, the first smaller one takes it,
  // the rest shift down. delete: slots not above the key shift up.
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (!ge) begin
        data <= prev_ge ? key : prev_data;
      end
    end else if (ctrl.del) begin
      if (!gt) begin
        data <= next_data;
      end
    end
  end

endmodule : mhq_cell
`default_nettype wire

[sv/max_heap_insert_delete_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// max_heap_insert_delete_unit: priority queue with insert and delete by value
// Entries live in a chain of cells kept in descending order; cell 0 is the
// top. Each request answers with status, top value and entry count.
//
//   channel   handshake      payload
//   request   start / busy   func, value
//   result    done           status, top_value, count
//
// A request is accepted in S_IDLE and then passes through S_CMP (compare in
// every cell), S_GRP (reduce the match flags in 16-wide groups), S_APPLY
// (update the chain) and S_RESP (present the result, done high). S_RESP
// returns to S_IDLE, so a new request is taken only after the last is done.
// busy is high from the cycle after accept through the done cycle. rst clears
// the count; cell contents are not reset. The result is shown for one cycle
// only; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module max_heap_insert_delete_unit #(
  parameter int CAPACITY = mhq_pkg::CAP_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                func,
  input  logic signed [mhq_pkg::DATA_W-1:0]   value,
  output logic                                done,
  output logic [1:0]                          status,
  output logic signed [mhq_pkg::DATA_W-1:0]   top_value,
  output logic [$clog2(CAPACITY + 1)-1:0]     count
);
  import mhq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NG = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CMP   = 5'b00010,
    S_GRP   = 5'b00100,
    S_APPLY = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t                     state, state_next;
  logic                       op_func;
  logic signed [DATA_W-1:0]   op_value;
  logic [CW-1:0]              fill, fill_next;
  logic [1:0]                 status_q, status_next;
  logic [NG-1:0]              grp;
  logic [NG*GROUP_SIZE-1:0]   eq_pad;
  logic                       full, found;
  cell_ctrl_t                 ctrl;

  logic signed [DATA_W-1:0]   cell_data [CAPACITY];
  logic [CAPACITY-1:0]        cell_ge;
  logic [CAPACITY-1:0]        cell_eq;

  assign full  = (fill == CW'(CAPACITY));
  assign found = |grp;

  always_comb begin
    ctrl.cmp = (state == S_CMP);
    ctrl.ins = (state == S_APPLY) && (op_func == FN_INSERT) && !full;
    ctrl.del = (state == S_APPLY) && (op_func == FN_DELETE) && found;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev_d, next_d;
    logic                     prev_g;
    if (i == 0) begin : g_first
      assign prev_d = op_value;
      assign prev_g = 1'b1;
    end else begin : g_mid
      assign prev_d = cell_data[i-1];
      assign prev_g = cell_ge[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_d = cell_data[i];
    end else begin : g_inner
      assign next_d = cell_data[i+1];
    end
    mhq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .key       (op_value),
      .valid     (CW'(i) < fill),
      .prev_data (prev_d),
      .prev_ge   (prev_g),
      .next_data (next_d),
      .data      (cell_data[i]),
      .ge        (cell_ge[i]),
      .eq        (cell_eq[i])
    );
  end

  always_comb begin
    eq_pad                 = '0;
    eq_pad[CAPACITY-1:0]   = cell_eq;
  end

  always_ff @(posedge clk) begin
    if (state == S_GRP) begin
      for (int g = 0; g < NG; g++) begin
        grp[g] <= |eq_pad[g*GROUP_SIZE +: GROUP_SIZE];
      end
    end
  end

  always_comb begin
    state_next  = state;
    fill_next   = fill;
    status_next = status_q;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_CMP;
      end
      S_CMP: begin
        state_next = S_GRP;
      end
      S_GRP: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        state_next = S_RESP;
        if (op_func == FN_INSERT) begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            status_next = ST_DONE;
            fill_next   = fill + 1'b1;
          end
        end else begin
          if (found) begin
            status_next = ST_DONE;
            fill_next   = fill - 1'b1;
          end else begin
            status_next = ST_NOT_FOUND;
          end
        end
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    status_q <= status_next;
    if (state == S_IDLE && start) begin
      op_func  <= func;
      op_value <= value;
    end
  end

  assign busy      = (state != S_IDLE);
  assign done      = (state == S_RESP);
  assign status    = status_q;
  assign top_value = (fill != '0) ? cell_data[0] : '0;
  assign count     = fill;

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_full_keeps: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && status_next == ST_FULL) |=> fill == $past(fill))
    else $error("refused insert changed the count");

  a_insert_top: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_DONE && op_func == FN_INSERT) |-> top_value >= op_value)
    else $error("top below inserted value");

endmodule : max_heap_insert_delete_unit
`default_nettype wire
